/* rtl/core/apc_pkg.sv */
// Shared types and constants for the apogee-triggered capture core.
// Used by apc_cal_div, apogee_triggered_capture_core and the testbench; no dependencies.

package apc_pkg;

    // Field widths of one request and one result
    localparam int ALT_W      = 18;
    localparam int IDX_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int HEIGHT_W   = 16;
    localparam int POST_W     = 10;
    localparam int CFG_IDX_W  = 2;

    // Relative altitude is the difference of two altitudes
    localparam int REL_W      = ALT_W + 1;
    // Post-apogee counter reaches the post limit plus one
    localparam int POST_CNT_W = POST_W + 1;

    // Byte scaling saturates at this value
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd254;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] ARM_HEIGHT_RST  = 16'd64;
    localparam logic [HEIGHT_W-1:0] DROP_HEIGHT_RST = 16'd48;
    localparam logic [POST_W-1:0]   POST_LIMIT_RST  = 10'd300;
    localparam logic [HEIGHT_W-1:0] BYTE_OFFSET_RST = 16'd160;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_OFFSET = 2'd3;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ARM    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    // Run phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAL  = 2'd1,
        PH_REC  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

endpackage

/* rtl/core/apogee_triggered_capture_core.sv */
// Apogee-triggered altitude capture: calibrates a ground level, tracks peak
// height, latches apogee and keeps a ring of scaled sample bytes for readout.
// Depends on apc_pkg and apc_cal_div.
//
// The core takes one request per clock unless result back-pressure fills the
// result stage, and returns exactly one result per request through the
// store's registered read port or the result stage, then the output register.
// All run state (calibration, peak, apogee, counters, ring pointers) updates
// in the cycle a request is accepted, and the store is written and read in
// that same cycle, so a read directly after a sample already sees its byte.
// The store needs no clearing after reset: the fill count bounds every read.
// Configuration writes are to be made while no request is outstanding.

module apogee_triggered_capture_core #(
    parameter int DEPTH       = 512,
    parameter int CAL_SAMPLES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [apc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apc_pkg::HEIGHT_W-1:0]  i_cfg_wdata,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata from bit 0: altitude[17:0], read_index[26:18], zero [31:27]
    input  logic [31:0] i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_tuser,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata from bit 0: data_byte[7:0], data_valid[8], phase[10:9],
    // apogee_seen[11], zero [15:12]
    output logic [15:0] o_m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int XW    = (AW + 2 > apc_pkg::IDX_W) ? AW + 2 : apc_pkg::IDX_W;
    localparam int SUM_W = apc_pkg::ALT_W + $clog2(CAL_SAMPLES);
    localparam int CW    = $clog2(CAL_SAMPLES + 1);
    localparam int WW    = apc_pkg::REL_W + 2;

    // Configuration registers
    logic [apc_pkg::HEIGHT_W-1:0] r_arm_height;
    logic [apc_pkg::HEIGHT_W-1:0] r_drop_height;
    logic [apc_pkg::POST_W-1:0]   r_post_limit;
    logic [apc_pkg::HEIGHT_W-1:0] r_byte_offset;

    // Run state
    apc_pkg::t_phase                   r_phase, n_phase;
    logic [CW-1:0]                     r_cal_count, n_cal_count;
    logic signed [SUM_W-1:0]           r_cal_sum, n_cal_sum;
    logic signed [apc_pkg::ALT_W-1:0]  r_ground, n_ground;
    logic signed [apc_pkg::REL_W-1:0]  r_peak, n_peak;
    logic                              r_apogee, n_apogee;
    logic [apc_pkg::POST_CNT_W-1:0]    r_post_count, n_post_count;
    logic [AW-1:0]                     r_wp, n_wp;
    logic [FW-1:0]                     r_fill, n_fill;

    // Sample store
    logic [apc_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [apc_pkg::BYTE_W-1:0] r_rd_data;

    // Result stage after acceptance, and output register
    logic                       r_s1_valid;
    logic [apc_pkg::BYTE_W-1:0] r_s1_byte;
    logic                       r_s1_flag;
    logic                       r_s1_from_mem;
    apc_pkg::t_phase            r_s1_phase;
    logic                       r_s1_apogee;
    logic                       r_out_valid;
    logic [15:0]                r_out_data;

    // Request decode
    apc_pkg::t_kind                   w_kind;
    logic signed [apc_pkg::ALT_W-1:0] w_alt;
    logic [apc_pkg::IDX_W-1:0]        w_idx;
    logic                             w_accept;
    logic                             w_s1_adv;

    // Per-request datapath
    logic signed [SUM_W-1:0]           w_sum_next;
    logic signed [apc_pkg::ALT_W-1:0]  w_quot;
    logic signed [apc_pkg::REL_W-1:0]  w_rel;
    logic signed [WW-1:0]              w_rel_x;
    logic signed [WW-1:0]              w_peak_x;
    logic signed [WW-1:0]              w_byte_sum;
    logic [apc_pkg::BYTE_W-1:0]        w_byte;
    logic                              w_mem_we;
    logic                              w_mem_re;
    logic [XW-1:0]                     w_raw_addr;
    logic [XW-1:0]                     w_wrap_addr;
    logic [AW-1:0]                     w_raddr;
    logic                              w_hit;
    logic [apc_pkg::BYTE_W-1:0]        w_res_byte;
    logic                              w_res_flag;

    assign w_kind   = apc_pkg::t_kind'(i_s_tuser);
    assign w_alt    = i_s_tdata[apc_pkg::ALT_W-1:0];
    assign w_idx    = i_s_tdata[apc_pkg::ALT_W +: apc_pkg::IDX_W];
    assign w_s1_adv = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_accept = i_s_tvalid && o_s_tready;

    // Ground level from the running calibration sum
    assign w_sum_next = r_cal_sum + SUM_W'(w_alt);

    apc_cal_div #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_cal_div (
        .i_sum  (w_sum_next),
        .o_quot (w_quot)
    );

    // Read address: oldest entry plus index, wrapped once around the ring
    always_comb begin
        w_hit       = XW'(w_idx) < XW'(r_fill);
        w_raw_addr  = XW'(r_wp) + XW'(DEPTH) - XW'(r_fill) + XW'(w_idx);
        w_wrap_addr = (w_raw_addr >= XW'(DEPTH)) ? w_raw_addr - XW'(DEPTH) : w_raw_addr;
        w_raddr     = w_wrap_addr[AW-1:0];
    end

    // Relative height and byte scaling
    always_comb begin
        w_rel      = apc_pkg::REL_W'(WW'(w_alt) - WW'(r_ground));
        w_rel_x    = WW'(w_rel);
        w_byte_sum = w_rel_x + WW'({1'b0, r_byte_offset});
        if (w_byte_sum < 0) begin
            w_byte = '0;
        end else if (w_byte_sum >= WW'(int'(apc_pkg::BYTE_MAX + 1) * 8)) begin
            w_byte = apc_pkg::BYTE_MAX;
        end else begin
            w_byte = w_byte_sum[3 +: apc_pkg::BYTE_W];
        end
    end

    // Next run state and result of the request being offered
    always_comb begin
        n_phase      = r_phase;
        n_cal_count  = r_cal_count;
        n_cal_sum    = r_cal_sum;
        n_ground     = r_ground;
        n_peak       = r_peak;
        n_apogee     = r_apogee;
        n_post_count = r_post_count;
        n_wp         = r_wp;
        n_fill       = r_fill;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_res_byte   = '0;
        w_res_flag   = 1'b0;
        w_peak_x     = WW'(r_peak);
        case (w_kind)
            apc_pkg::KIND_ARM: begin
                n_phase      = apc_pkg::PH_CAL;
                n_cal_count  = '0;
                n_cal_sum    = '0;
                n_ground     = '0;
                n_peak       = '0;
                n_apogee     = 1'b0;
                n_post_count = '0;
                n_wp         = '0;
                n_fill       = '0;
            end
            apc_pkg::KIND_SAMPLE: begin
                if (r_phase == apc_pkg::PH_CAL) begin
                    // Accumulate; the last sample fixes the ground level
                    n_cal_sum   = w_sum_next;
                    n_cal_count = r_cal_count + 1'b1;
                    if (r_cal_count == CW'(CAL_SAMPLES - 1)) begin
                        n_ground = w_quot;
                        n_phase  = apc_pkg::PH_REC;
                    end
                end else if (r_phase == apc_pkg::PH_REC) begin
                    // Track peak, latch apogee, store the byte
                    if (w_rel > r_peak) begin
                        n_peak = w_rel;
                    end
                    w_peak_x = WW'(n_peak);
                    if (w_peak_x > WW'($signed({1'b0, r_arm_height})) &&
                        w_rel_x < w_peak_x - WW'($signed({1'b0, r_drop_height}))) begin
                        n_apogee = 1'b1;
                    end
                    if (n_apogee) begin
                        n_post_count = r_post_count + 1'b1;
                    end
                    w_mem_we   = 1'b1;
                    w_res_byte = w_byte;
                    w_res_flag = 1'b1;
                    n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    if (r_fill != FW'(DEPTH)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (n_post_count > apc_pkg::POST_CNT_W'(r_post_limit)) begin
                        n_phase = apc_pkg::PH_DONE;
                    end
                end
            end
            apc_pkg::KIND_READ: begin
                w_mem_re   = w_hit;
                w_res_flag = w_hit;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_height  <= apc_pkg::ARM_HEIGHT_RST;
            r_drop_height <= apc_pkg::DROP_HEIGHT_RST;
            r_post_limit  <= apc_pkg::POST_LIMIT_RST;
            r_byte_offset <= apc_pkg::BYTE_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                apc_pkg::CFG_ARM_HEIGHT:  r_arm_height  <= i_cfg_wdata;
                apc_pkg::CFG_DROP_HEIGHT: r_drop_height <= i_cfg_wdata;
                apc_pkg::CFG_POST_LIMIT:  r_post_limit  <= i_cfg_wdata[apc_pkg::POST_W-1:0];
                apc_pkg::CFG_BYTE_OFFSET: r_byte_offset <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Run state: advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= apc_pkg::PH_IDLE;
            r_cal_count  <= '0;
            r_cal_sum    <= '0;
            r_ground     <= '0;
            r_peak       <= '0;
            r_apogee     <= 1'b0;
            r_post_count <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_cal_count  <= n_cal_count;
            r_cal_sum    <= n_cal_sum;
            r_ground     <= n_ground;
            r_peak       <= n_peak;
            r_apogee     <= n_apogee;
            r_post_count <= n_post_count;
            r_wp         <= n_wp;
            r_fill       <= n_fill;
        end
    end

    // Sample store: write at the write pointer, registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && w_mem_we) begin
            r_mem[r_wp] <= w_byte;
        end
        if (w_accept && w_mem_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Result stage: hold while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_byte     <= w_res_byte;
            r_s1_flag     <= w_res_flag;
            r_s1_from_mem <= w_mem_re;
            r_s1_phase    <= n_phase;
            r_s1_apogee   <= n_apogee;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_data <= {4'b0000, r_s1_apogee, r_s1_phase, r_s1_flag,
                           r_s1_from_mem ? r_rd_data : r_s1_byte};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* rtl/core/apc_cal_div.sv */
// Ground level from the calibration sum: signed truncating division by a
// constant, done as a reciprocal multiply. Depends on apc_pkg.

module apc_cal_div #(
    parameter int CAL_SAMPLES = 10,
    parameter int SUM_W       = 22
) (
    input  logic signed [SUM_W-1:0]          i_sum,
    output logic signed [apc_pkg::ALT_W-1:0] o_quot
);

    // Shift and reciprocal chosen so that the floor is exact for any
    // magnitude below 2**SUM_W
    localparam int L_W   = $clog2(CAL_SAMPLES);
    localparam int SHIFT = SUM_W + L_W;
    localparam int REC_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + REC_W;
    localparam int QUOT_W = PROD_W - SHIFT;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [REC_W-1:0] RECIP = RECIP_L[REC_W-1:0];

    logic              w_neg;
    logic [SUM_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] w_quot_mag;
    logic [QUOT_W-1:0] w_quot;

    // Divide the magnitude, then restore the sign (truncates toward zero)
    always_comb begin
        w_neg      = i_sum[SUM_W-1];
        w_mag      = w_neg ? (~i_sum + 1'b1) : i_sum;
        w_prod     = PROD_W'(w_mag) * PROD_W'(RECIP);
        w_quot_mag = w_prod[PROD_W-1:SHIFT];
        w_quot     = w_neg ? (~w_quot_mag + 1'b1) : w_quot_mag;
        o_quot     = w_quot[apc_pkg::ALT_W-1:0];
    end

endmodule

/* test/apc_capture_checker.sv */
// Scoreboard for the apogee-triggered capture core: watches the config port
// and both streams, predicts every result and compares. Depends on apc_pkg.
`timescale 1ns / 1ps

module apc_capture_checker #(
    parameter int DEPTH       = 512,
    parameter int CAL_SAMPLES = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [apc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apc_pkg::HEIGHT_W-1:0]  i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // tdata from bit 0: altitude[17:0], read_index[26:18], zero [31:27]
    input  logic [31:0]                   i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // tdata from bit 0: data_byte[7:0], data_valid[8], phase[10:9],
    // apogee_seen[11], zero [15:12]
    input  logic [15:0]                   i_m_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [apc_pkg::BYTE_W-1:0] data_byte;
        logic                       data_valid;
        apc_pkg::t_phase            phase;
        logic                       apogee_seen;
    } t_capture_result;

    // Register copies
    int arm_h, drop_h, post_lim, offset;

    // Run state
    apc_pkg::t_phase            run_phase;
    int                         cal_seen, cal_total, ground, peak, post_seen;
    int                         wr_ptr, stored;
    logic                       apogee;
    logic [apc_pkg::BYTE_W-1:0] byte_ring [DEPTH];

    t_capture_result expected_results [$];
    t_capture_result want, got;
    int              mismatches;

    function automatic void clear_run();
        cal_seen  = 0;
        cal_total = 0;
        ground    = 0;
        peak      = 0;
        apogee    = 1'b0;
        post_seen = 0;
        wr_ptr    = 0;
        stored    = 0;
    endfunction

    // Advance the run state by one request and return the result it causes
    function automatic t_capture_result predict_capture(input logic [1:0] kind,
                                                        input logic [31:0] data);
        t_capture_result res;
        int alt, rel, scaled, idx;
        res = '0;
        case (kind)
            apc_pkg::KIND_ARM: begin
                clear_run();
                run_phase = apc_pkg::PH_CAL;
            end
            apc_pkg::KIND_SAMPLE: begin
                alt = $signed(data[apc_pkg::ALT_W-1:0]);
                if (run_phase == apc_pkg::PH_CAL) begin
                    // accumulate towards the ground level
                    cal_total += alt;
                    cal_seen++;
                    if (cal_seen >= CAL_SAMPLES) begin
                        ground    = cal_total / CAL_SAMPLES;
                        run_phase = apc_pkg::PH_REC;
                    end
                end else if (run_phase == apc_pkg::PH_REC) begin
                    rel = alt - ground;
                    if (rel > peak)
                        peak = rel;
                    if (peak > arm_h && rel < peak - drop_h)
                        apogee = 1'b1;
                    if (apogee)
                        post_seen++;
                    // scale to a byte, saturating at both ends
                    scaled = rel + offset;
                    if (scaled < 0)
                        res.data_byte = '0;
                    else if ((scaled >>> 3) > int'(apc_pkg::BYTE_MAX))
                        res.data_byte = apc_pkg::BYTE_MAX;
                    else
                        res.data_byte = apc_pkg::BYTE_W'(scaled >>> 3);
                    res.data_valid    = 1'b1;
                    byte_ring[wr_ptr] = res.data_byte;
                    wr_ptr            = (wr_ptr + 1) % DEPTH;
                    if (stored < DEPTH)
                        stored++;
                    if (post_seen > post_lim)
                        run_phase = apc_pkg::PH_DONE;
                end
            end
            apc_pkg::KIND_READ: begin
                idx = data[apc_pkg::ALT_W +: apc_pkg::IDX_W];
                if (idx < stored) begin
                    res.data_byte  = byte_ring[(wr_ptr + DEPTH - stored + idx) % DEPTH];
                    res.data_valid = 1'b1;
                end
            end
            default: ;
        endcase
        res.phase       = run_phase;
        res.apogee_seen = apogee;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arm_h     = apc_pkg::ARM_HEIGHT_RST;
            drop_h    = apc_pkg::DROP_HEIGHT_RST;
            post_lim  = apc_pkg::POST_LIMIT_RST;
            offset    = apc_pkg::BYTE_OFFSET_RST;
            run_phase = apc_pkg::PH_IDLE;
            clear_run();
            expected_results.delete();
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    apc_pkg::CFG_ARM_HEIGHT:  arm_h    = i_cfg_wdata;
                    apc_pkg::CFG_DROP_HEIGHT: drop_h   = i_cfg_wdata;
                    apc_pkg::CFG_POST_LIMIT:  post_lim = i_cfg_wdata[apc_pkg::POST_W-1:0];
                    apc_pkg::CFG_BYTE_OFFSET: offset   = i_cfg_wdata;
                    default: ;
                endcase
            end

            // Compare a delivered result with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got.data_byte   = i_m_tdata[7:0];
                got.data_valid  = i_m_tdata[8];
                got.phase       = apc_pkg::t_phase'(i_m_tdata[10:9]);
                got.apogee_seen = i_m_tdata[11];
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", i_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.data_byte !== want.data_byte) begin
                        $error("data_byte expected %0d got %0d", want.data_byte,
                               got.data_byte);
                        mismatches++;
                    end
                    if (got.data_valid !== want.data_valid) begin
                        $error("data_valid expected %0d got %0d", want.data_valid,
                               got.data_valid);
                        mismatches++;
                    end
                    if (got.phase !== want.phase) begin
                        $error("phase expected %0d got %0d", want.phase, got.phase);
                        mismatches++;
                    end
                    if (got.apogee_seen !== want.apogee_seen) begin
                        $error("apogee_seen expected %0d got %0d", want.apogee_seen,
                               got.apogee_seen);
                        mismatches++;
                    end
                end
            end

            // Predict the result of an accepted request
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_capture(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

/* test/apogee_triggered_capture_core_test.sv */
// Top of the capture core testbench: clock, reset, register settings, flight
// profiles and noise as stimulus, verdict. Depends on apc_pkg, the core and
// apc_capture_checker.
`timescale 1ns / 1ps

module apogee_triggered_capture_core_test;

    localparam int DEPTH         = 512;
    localparam int CAL_SAMPLES   = 10;
    localparam int SECTION_ITEMS = 200;
    localparam int SECTIONS      = 6;
    localparam int WRAP_SAMPLES  = 530;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ALT_MIN       = -131072;
    localparam int ALT_MAX       = 131071;
    // Kind code the core has no operation for
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [apc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [apc_pkg::HEIGHT_W-1:0]  i_cfg_wdata;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    // tdata from bit 0: altitude[17:0], read_index[26:18], zero [31:27]
    logic [31:0]                   i_s_tdata;
    // tuser: kind[1:0]
    logic [1:0]                    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    // tdata from bit 0: data_byte[7:0], data_valid[8], phase[10:9],
    // apogee_seen[11], zero [15:12]
    logic [15:0]                   o_m_tdata;

    int          fail_count;
    int          results_pending;
    int unsigned cycle_count;
    int          src_idle_pct;
    int          dst_idle_pct;
    int          requests_sent;
    int          cfg_arm;
    int          cfg_drop;

    apogee_triggered_capture_core #(
        .DEPTH       (DEPTH),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    apc_capture_checker #(
        .DEPTH       (DEPTH),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle budget for the whole run
    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL apogee_triggered_capture_core");
        $finish;
    end

    // Result side back-pressure
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // Offer one request after random gaps and hold it until accepted.
    // Called and returns at a falling edge; the caller lowers valid or
    // offers the next request in that same step.
    task automatic send_request(input logic [1:0] kind, input int alt, input int idx);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {5'd0, idx[apc_pkg::IDX_W-1:0], alt[apc_pkg::ALT_W-1:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Sample with the altitude held inside the field's range
    task automatic send_altitude(input int alt);
        if (alt > ALT_MAX)
            alt = ALT_MAX;
        if (alt < ALT_MIN)
            alt = ALT_MIN;
        send_request(apc_pkg::KIND_SAMPLE, alt, $urandom_range(0, 511));
    endtask

    // Read, mostly near the oldest bytes, sometimes anywhere
    task automatic maybe_read();
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 1))
                send_request(apc_pkg::KIND_READ, $urandom, $urandom_range(0, 63));
            else
                send_request(apc_pkg::KIND_READ, $urandom, $urandom_range(0, 511));
        end
    endtask

    task automatic write_register(input logic [apc_pkg::CFG_IDX_W-1:0] idx,
                                  input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[apc_pkg::HEIGHT_W-1:0];
        @(negedge i_clk);
    endtask

    // Wait for the core to go quiet, then write all four registers
    task automatic apply_settings(input int arm, input int drop, input int post,
                                  input int off);
        i_s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_register(apc_pkg::CFG_ARM_HEIGHT, arm);
        write_register(apc_pkg::CFG_DROP_HEIGHT, drop);
        write_register(apc_pkg::CFG_POST_LIMIT, post);
        write_register(apc_pkg::CFG_BYTE_OFFSET, off);
        i_cfg_we <= 1'b0;
        cfg_arm  = arm;
        cfg_drop = drop;
    endtask

    // One flight: arm, calibrate at ground, climb, fall, then hover; cut
    // short once the request count reaches stop_at
    task automatic fly(input int stop_at);
        int ground, peak, fall, n_up, n_dn, n_tail, i;
        if ($urandom_range(0, 3) == 0)
            ground = int'($urandom_range(0, 262143)) + ALT_MIN;
        else
            ground = int'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 3))
            0:       peak = $urandom_range(0, cfg_arm + 16);
            3:       peak = $urandom_range(0, 262143);
            default: peak = cfg_arm + int'($urandom_range(1, 3000));
        endcase
        fall   = peak + int'($urandom_range(0, 2000));
        n_up   = $urandom_range(3, 40);
        n_dn   = $urandom_range(3, 60);
        n_tail = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 650) : $urandom_range(0, 20);

        send_request(apc_pkg::KIND_ARM, $urandom, $urandom);
        for (i = 0; i < CAL_SAMPLES && requests_sent < stop_at; i++)
            send_altitude(ground + int'($urandom_range(0, 8)) - 4);
        for (i = 1; i <= n_up && requests_sent < stop_at; i++) begin
            send_altitude(ground + peak * i / n_up + int'($urandom_range(0, 6)) - 3);
            maybe_read();
        end
        for (i = 1; i <= n_dn && requests_sent < stop_at; i++) begin
            send_altitude(ground + peak - fall * i / n_dn + int'($urandom_range(0, 6)) - 3);
            maybe_read();
        end
        for (i = 0; i < n_tail && requests_sent < stop_at; i++) begin
            send_altitude(ground + peak - fall + int'($urandom_range(0, 6)) - 3);
            maybe_read();
        end
    endtask

    initial begin
        int section, target, i;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        src_idle_pct  = 35;
        dst_idle_pct  = 58;
        requests_sent = 0;
        cfg_arm       = apc_pkg::ARM_HEIGHT_RST;
        cfg_drop      = apc_pkg::DROP_HEIGHT_RST;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: short post-apogee window so the done phase is reached
        apply_settings(apc_pkg::ARM_HEIGHT_RST, apc_pkg::DROP_HEIGHT_RST, 2,
                       apc_pkg::BYTE_OFFSET_RST);
        send_request(apc_pkg::KIND_READ, 0, 0);            // empty store, first index
        send_request(apc_pkg::KIND_READ, 0, 511);          // empty store, last index
        send_request(apc_pkg::KIND_SAMPLE, ALT_MAX, 0);    // sample while idle
        send_request(KIND_SPARE, ALT_MIN, 511);            // unused kind
        send_request(apc_pkg::KIND_ARM, 0, 0);
        // ground sum -41 truncates to -4, not -5
        send_altitude(ALT_MAX);
        send_altitude(ALT_MIN);
        for (i = 0; i < CAL_SAMPLES - 2; i++)
            send_altitude(-5);
        send_altitude(ALT_MIN);                   // byte clamps low
        send_altitude(ALT_MAX);                   // byte clamps high, new peak
        send_altitude(ALT_MIN);                   // deep fall: apogee
        send_request(apc_pkg::KIND_READ, 0, 0);   // oldest byte
        send_altitude(100);
        send_altitude(100);                       // window closes: done
        send_altitude(0);                         // sample while done
        send_request(apc_pkg::KIND_READ, 0, 4);   // newest byte
        send_request(apc_pkg::KIND_READ, 0, 5);   // just past the stored count
        send_request(apc_pkg::KIND_ARM, 0, 0);    // arm while done
        send_request(apc_pkg::KIND_ARM, 0, 0);    // arm while calibrating

        // Directed: stay below the arm height so the ring wraps and fills up
        for (i = 0; i < CAL_SAMPLES; i++)
            send_altitude(int'($urandom_range(0, 8)) - 4);
        for (i = 0; i < WRAP_SAMPLES; i++) begin
            send_altitude(int'($urandom_range(0, 40)));
            if (i % 64 == 0)
                send_request(apc_pkg::KIND_READ, 0, $urandom_range(0, 511));
        end
        send_request(apc_pkg::KIND_READ, 0, 0);   // oldest byte of a full ring
        send_request(apc_pkg::KIND_READ, 0, 511); // newest byte of a full ring

        // Random flights and noise over several settings and idle patterns
        for (section = 0; section < SECTIONS; section++) begin
            case (section)
                0: apply_settings(0, 0, 0, 0);
                1: apply_settings(65535, 65535, 1023, 65535);
                default: apply_settings($urandom_range(0, 3000), $urandom_range(0, 400),
                                        $urandom_range(0, 120),
                                        $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                             : $urandom_range(0, 65535));
            endcase
            if (section < 2) begin
                src_idle_pct = 35;
                dst_idle_pct = 58;
            end else if (section < 4) begin
                src_idle_pct = 58;
                dst_idle_pct = 35;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            target = requests_sent + SECTION_ITEMS;
            while (requests_sent < target) begin
                if ($urandom_range(0, 9) < 8)
                    fly(target);
                else
                    repeat ($urandom_range(1, 6))
                        send_request($urandom_range(0, 3), $urandom, $urandom);
            end
        end

        // Let every outstanding result come back
        i_s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS apogee_triggered_capture_core");
        else
            $display("FAIL apogee_triggered_capture_core");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/apc_pkg.sv
rtl/core/apc_cal_div.sv
rtl/core/apogee_triggered_capture_core.sv
test/apc_capture_checker.sv
test/apogee_triggered_capture_core_test.sv
